/* hdl/brb_pkg.sv */
// ============================================================================
// brb_pkg: shared definitions for the byte ring buffer with peek
// Request codes, field widths, default sizes and the result metadata record.
// ============================================================================
`default_nettype none

package brb_pkg;

    // Field widths fixed by the stream and register formats.
    localparam int CAP_W   = 9;
    localparam int LEN_W   = 4;
    localparam int SKIP_W  = 8;
    localparam int LEVEL_W = 8;
    localparam int DATA_W  = 64;
    localparam int TYPE_W  = 2;

    // Default sizes and the capacity after reset.
    localparam int DEPTH_DEF = 256;
    localparam int LANES_DEF = 8;
    localparam int CAP_RESET = 256;

    // Register word index of the capacity register.
    localparam logic REG_CAPACITY = 1'b0;

    // Request codes.
    localparam logic [TYPE_W-1:0] REQ_POST     = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_POST_ALL = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_PULL     = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_PEEK     = 2'd3;

    // Result fields that travel with a request while its bytes are read.
    typedef struct packed {
        logic               status;
        logic [LEN_W-1:0]   count;
        logic               is_read;
        logic [LEVEL_W-1:0] fill;
        logic [LEVEL_W-1:0] free;
    } meta_t;

endpackage

`default_nettype wire

/* hdl/byte_ring_buffer_with_peek.sv */
// ============================================================================
// byte_ring_buffer_with_peek
// Circular byte FIFO with multi-byte post, all-or-nothing post, pull and peek.
// ============================================================================
// The buffer takes one request per clock cycle while the result stream is
// not stalled, and returns each result through the synchronous read of the
// banked byte memory and the output register. Bytes are kept in LANES (rounded
// up to a power of two) byte-wide banks, indexed by a running byte sequence
// number, so that one request touches each bank at most once. The usable space
// is capacity minus one; writing the capacity register empties the buffer.
// Error results carry a zero count and zero data, and change nothing.
`default_nettype none

module byte_ring_buffer_with_peek
    import brb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int LANES = LANES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Request stream.
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // [3:0] length, [11:4] skip, [75:12] data_in, [79:76] zero
    input  wire logic [79:0]       s_axis_tdata,
    // [1:0] req_type
    input  wire logic [TYPE_W-1:0] s_axis_tuser,
    // Result stream.
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // [3:0] byte_count, [67:4] data_out, [75:68] fill_level,
    // [83:76] free_level, [87:84] zero
    output logic [87:0]            m_axis_tdata,
    // [0] status
    output logic                   m_axis_tuser,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // Bank count is LANES rounded up to a power of two, at least two.
    localparam int NB     = (LANES <= 2) ? 2 : ((LANES <= 4) ? 4 : 8);
    localparam int NBW    = $clog2(NB);
    localparam int DAW    = $clog2(DEPTH);
    localparam int SEQ_AW = (DAW > NBW + 1) ? DAW : NBW + 1;
    localparam int RW     = SEQ_AW - NBW;
    localparam int ROWS   = 2 ** RW;
    localparam int SUM_W  = (SEQ_AW > SKIP_W) ? SEQ_AW : SKIP_W;

    localparam int CAP_MAX_I = (DEPTH < 511) ? DEPTH : 511;
    localparam int CAP_RST_I = (CAP_RESET < DEPTH) ? CAP_RESET : DEPTH;
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_MAX_I);
    localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
    localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(CAP_RST_I);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LANES);

    // Request fields.
    logic [TYPE_W-1:0] req_type;
    logic [LEN_W-1:0]  req_len;
    logic [SKIP_W-1:0] req_skip;
    logic [7:0]        din_lane [8];

    assign req_type = s_axis_tuser;
    assign req_len  = s_axis_tdata[3:0];
    assign req_skip = s_axis_tdata[11:4];

    for (genvar l = 0; l < 8; l++) begin : g_din
        assign din_lane[l] = s_axis_tdata[12 + 8*l +: 8];
    end

    // Buffer state: sequence numbers of the oldest and next bytes, fill, size.
    logic [SEQ_AW-1:0] rd_seq_reg, rd_seq_next;
    logic [SEQ_AW-1:0] wr_seq_reg, wr_seq_next;
    logic [CAP_W-1:0]  fill_reg, fill_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;

    // Pipeline control.
    logic  s1_valid_reg;
    meta_t s1_meta_reg;
    logic [NBW-1:0] s1_base_reg;
    logic  m_valid_reg;
    logic  m_status_reg;
    logic [87:0] m_data_reg;
    logic  s_fire;
    logic  s1_adv;
    logic  cfg_wr;

    assign s1_adv        = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Configuration register access.
    logic [CAP_W-1:0] cfg_val;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign cfg_val = pwdata[CAP_W-1:0];
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_reg} : 32'd0;

    // Request decode: check the request and work out how many bytes it moves.
    logic [LEN_W-1:0]  len_sat;
    logic [CAP_W-1:0]  len9;
    logic [CAP_W-1:0]  room;
    logic [CAP_W-1:0]  avail;
    logic              req_err;
    logic [LEN_W-1:0]  req_count;
    logic [SEQ_AW-1:0] base_seq;
    logic [SUM_W-1:0]  peek_sum;
    logic              is_post;
    logic              is_read;

    assign len_sat  = (req_len > LEN_MAX) ? LEN_MAX : req_len;
    assign len9     = CAP_W'(len_sat);
    assign room     = cap_reg - CAP_W'(1) - fill_reg;
    assign avail    = fill_reg - CAP_W'(req_skip);
    assign peek_sum = SUM_W'(rd_seq_reg) + SUM_W'(req_skip);

    always_comb begin
        req_err   = 1'b0;
        req_count = '0;
        base_seq  = rd_seq_reg;
        is_post   = 1'b0;
        is_read   = 1'b0;
        unique case (req_type)
            REQ_POST: begin
                is_post   = 1'b1;
                base_seq  = wr_seq_reg;
                req_err   = (room == '0);
                req_count = (len9 < room) ? len_sat : room[LEN_W-1:0];
            end
            REQ_POST_ALL: begin
                is_post   = 1'b1;
                base_seq  = wr_seq_reg;
                req_err   = (len9 > room);
                req_count = len_sat;
            end
            REQ_PULL: begin
                is_read   = 1'b1;
                req_err   = (fill_reg == '0);
                req_count = (len9 < fill_reg) ? len_sat : fill_reg[LEN_W-1:0];
            end
            REQ_PEEK: begin
                is_read   = 1'b1;
                base_seq  = peek_sum[SEQ_AW-1:0];
                req_err   = (CAP_W'(req_skip) >= fill_reg);
                req_count = (len9 < avail) ? len_sat : avail[LEN_W-1:0];
            end
            default: begin
                req_err = 1'b1;
            end
        endcase
        if (len_sat == '0) begin
            req_err = 1'b1;
        end
        if (req_err) begin
            req_count = '0;
        end
    end

    // Next buffer state.
    logic [CAP_W-1:0] count9;

    assign count9 = CAP_W'(req_count);

    always_comb begin
        rd_seq_next = rd_seq_reg;
        wr_seq_next = wr_seq_reg;
        fill_next   = fill_reg;
        cap_next    = cap_reg;
        if (cfg_wr) begin
            rd_seq_next = '0;
            wr_seq_next = '0;
            fill_next   = '0;
            if (cfg_val < CAP_MIN) begin
                cap_next = CAP_MIN;
            end else if (cfg_val > CAP_MAX) begin
                cap_next = CAP_MAX;
            end else begin
                cap_next = cfg_val;
            end
        end else if (s_fire && !req_err) begin
            if (is_post) begin
                wr_seq_next = wr_seq_reg + SEQ_AW'(req_count);
                fill_next   = fill_reg + count9;
            end else if (req_type == REQ_PULL) begin
                rd_seq_next = rd_seq_reg + SEQ_AW'(req_count);
                fill_next   = fill_reg - count9;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_seq_reg <= '0;
            wr_seq_reg <= '0;
            fill_reg   <= '0;
            cap_reg    <= CAP_RST;
        end else begin
            rd_seq_reg <= rd_seq_next;
            wr_seq_reg <= wr_seq_next;
            fill_reg   <= fill_next;
            cap_reg    <= cap_next;
        end
    end

    // Banked byte memory: byte with sequence number n lives in bank n mod NB.
    logic [7:0] bank_rd [NB];
    logic       wr_en;

    assign wr_en = s_fire && is_post && !req_err;

    for (genvar b = 0; b < NB; b++) begin : g_bank
        logic [7:0]        mem_r [ROWS];
        logic [7:0]        rd_data_reg;
        logic [NBW-1:0]    lane_off;
        logic [SEQ_AW-1:0] seq_addr;
        logic [RW-1:0]     row;
        logic              bank_we;

        assign lane_off = NBW'(b) - base_seq[NBW-1:0];
        assign seq_addr = base_seq + SEQ_AW'(lane_off);
        assign row      = seq_addr[SEQ_AW-1:NBW];
        assign bank_we  = wr_en && (LEN_W'(lane_off) < req_count);

        always_ff @(posedge aclk) begin
            if (bank_we) begin
                mem_r[row] <= din_lane[3'(lane_off)];
            end
            if (s_fire) begin
                rd_data_reg <= mem_r[row];
            end
        end

        assign bank_rd[b] = rd_data_reg;
    end

    // Read stage: metadata waits here alongside the memory read.
    meta_t            s0_meta;
    logic [CAP_W-1:0] free_after;

    assign free_after      = cap_reg - CAP_W'(1) - fill_next;
    assign s0_meta.status  = req_err;
    assign s0_meta.count   = req_count;
    assign s0_meta.is_read = is_read && !req_err;
    assign s0_meta.fill    = fill_next[LEVEL_W-1:0];
    assign s0_meta.free    = free_after[LEVEL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_meta_reg <= s0_meta;
            s1_base_reg <= base_seq[NBW-1:0];
        end
    end

    // Lane alignment: rotate the bank outputs so the first byte is in lane 0.
    logic [DATA_W-1:0] dout;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (s1_meta_reg.is_read && (LEN_W'(i) < s1_meta_reg.count)) begin
                dout[8*i +: 8] = bank_rd[NBW'(s1_base_reg + NBW'(i))];
            end else begin
                dout[8*i +: 8] = 8'd0;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_status_reg <= s1_meta_reg.status;
            m_data_reg   <= {4'd0, s1_meta_reg.free, s1_meta_reg.fill, dout,
                             s1_meta_reg.count};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks.
    a_fill_below_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < cap_reg)
        else $error("fill level reached the capacity");

    a_seq_matches_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_seq_reg - rd_seq_reg) == SEQ_AW'(fill_reg))
        else $error("sequence numbers disagree with the fill level");

    a_cap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cap_reg >= CAP_MIN) && (cap_reg <= CAP_MAX))
        else $error("capacity out of range");

    a_err_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[3:0] == '0) && (m_axis_tdata[67:4] == '0))
        else $error("rejected request carries bytes");

    a_cfg_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> (fill_reg == '0))
        else $error("capacity write did not empty the buffer");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// Testbench for byte_ring_buffer_with_peek
// Sends post, all-or-nothing post, pull and peek requests into the buffer
// over the request stream and changes the ring size over the register port.
// A tracker keeps its own copy of the ring and pointers, works out the result
// of every accepted request, and compares each returned result, field by
// field, with the oldest outstanding prediction. Both stream sides idle and
// stall at random in phases, and the run covers several ring sizes,
// including the smallest and the largest.
// ============================================================================
module testbench;
    import brb_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_PHASES    = 9;
    localparam int PHASE_ITEMS   = 75;
    localparam int RING_AW       = $clog2(DEPTH_DEF);

    // One result as it leaves the buffer, fields in the order of the port.
    typedef struct packed {
        logic               status;
        logic [LEN_W-1:0]   count;
        logic [DATA_W-1:0]  data;
        logic [LEVEL_W-1:0] fill;
        logic [LEVEL_W-1:0] free;
    } ring_result_t;

    // Tracks the ring contents and pointers and holds the predicted results.
    class byte_ring_tracker;
        logic [7:0]   ring_bytes [DEPTH_DEF];
        int unsigned  rd_ptr;
        int unsigned  wr_ptr;
        int unsigned  ring_size;
        ring_result_t pending_q[$];
        int unsigned  mismatches;
        int unsigned  results_seen;
        int unsigned  rejects;
        int unsigned  full_hits;
        int unsigned  wraps;
        int unsigned  kind_count [4];

        function new();
            rd_ptr       = 0;
            wr_ptr       = 0;
            ring_size    = CAP_RESET;
            mismatches   = 0;
            results_seen = 0;
            rejects      = 0;
            full_hits    = 0;
            wraps        = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function int unsigned level();
            if (wr_ptr >= rd_ptr)
                return wr_ptr - rd_ptr;
            return ring_size - (rd_ptr - wr_ptr);
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function int unsigned step_ptr(int unsigned p);
            if (p + 1 >= ring_size) begin
                wraps++;
                return 0;
            end
            return p + 1;
        endfunction

        // A register write clamps the size and empties the ring.
        function void set_capacity(logic [31:0] value);
            int unsigned v;
            v = 32'(value[CAP_W-1:0]);
            if (v < 2)
                v = 2;
            if (v > DEPTH_DEF)
                v = DEPTH_DEF;
            ring_size = v;
            rd_ptr    = 0;
            wr_ptr    = 0;
        endfunction

        // Predict the result of one accepted request and update the ring.
        function void note_request(logic [TYPE_W-1:0] kind, logic [LEN_W-1:0] len_in,
                                   logic [SKIP_W-1:0] skip, logic [DATA_W-1:0] din);
            int unsigned  fill;
            int unsigned  room;
            int unsigned  len;
            int unsigned  avail;
            int unsigned  p;
            logic         err;
            ring_result_t r;
            fill  = level();
            room  = ring_size - 1 - fill;
            len   = (len_in > LEN_W'(LANES_DEF)) ? LANES_DEF : 32'(len_in);
            err   = 1'b0;
            r     = '0;
            kind_count[kind]++;
            if (len == 0) begin
                err = 1'b1;
            end else if (kind == REQ_POST || kind == REQ_POST_ALL) begin
                if (kind == REQ_POST) begin
                    if (room == 0)
                        err = 1'b1;
                    else
                        r.count = LEN_W'((len < room) ? len : room);
                end else begin
                    if (len > room)
                        err = 1'b1;
                    else
                        r.count = LEN_W'(len);
                end
                if (!err) begin
                    for (int i = 0; i < int'(r.count); i++) begin
                        ring_bytes[RING_AW'(wr_ptr)] = din[8*i +: 8];
                        wr_ptr = step_ptr(wr_ptr);
                    end
                end
            end else if (kind == REQ_PULL) begin
                if (fill == 0) begin
                    err = 1'b1;
                end else begin
                    r.count = LEN_W'((len < fill) ? len : fill);
                    for (int i = 0; i < int'(r.count); i++) begin
                        r.data[8*i +: 8] = ring_bytes[RING_AW'(rd_ptr)];
                        rd_ptr = step_ptr(rd_ptr);
                    end
                end
            end else begin
                // Peek: copy from skip bytes past the read pointer, move nothing.
                if (32'(skip) >= fill) begin
                    err = 1'b1;
                end else begin
                    avail   = fill - 32'(skip);
                    r.count = LEN_W'((len < avail) ? len : avail);
                    p = rd_ptr + 32'(skip);
                    if (p >= ring_size)
                        p -= ring_size;
                    for (int i = 0; i < int'(r.count); i++) begin
                        r.data[8*i +: 8] = ring_bytes[RING_AW'(p)];
                        p = step_ptr(p);
                    end
                end
            end
            if (err) begin
                r.count = '0;
                r.data  = '0;
                rejects++;
            end
            r.status = err;
            r.fill   = LEVEL_W'(level());
            r.free   = LEVEL_W'(ring_size - 1 - level());
            if (level() == ring_size - 1)
                full_hits++;
            pending_q.push_back(r);
        endfunction

        // Compare one returned result with the oldest prediction.
        function void check_result(ring_result_t got);
            ring_result_t want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result with no request outstanding: status %0d count %0d"
                             , got.status, got.count);
                return;
            end
            want = pending_q.pop_front();
            results_seen++;
            if (got.status !== want.status || got.count !== want.count ||
                got.data !== want.data || got.fill !== want.fill ||
                got.free !== want.free) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result %0d differs", results_seen);
                    $display("  expected status %0d count %0d data %h fill %0d free %0d",
                             want.status, want.count, want.data, want.fill, want.free);
                    $display("  actual   status %0d count %0d data %h fill %0d free %0d",
                             got.status, got.count, got.data, got.fill, got.free);
                end
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [79:0]         s_axis_tdata;
    logic [TYPE_W-1:0]   s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [87:0]         m_axis_tdata;
    logic                m_axis_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    byte_ring_tracker    tracker;
    int unsigned         cycle_count    = 0;
    int unsigned         sender_idle_pct = 0;
    int unsigned         recv_stall_pct  = 0;
    int unsigned         capacity_writes = 0;

    // Ring sizes written in the random part, raw values including out-of-range ones.
    logic [31:0] phase_cap [NUM_PHASES] = '{32'd511, 32'd1, 32'd3, 32'hFFFF_FE07, 32'd0,
                                            32'd300, 32'd17, 32'd256, 32'd100};

    byte_ring_buffer_with_peek DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, tracker.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(negedge aclk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Both handshakes are sampled at the same edge; the request is noted first.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_request(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[11:4],
                                     s_axis_tdata[75:12]);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result({m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[67:4],
                                      m_axis_tdata[75:68], m_axis_tdata[83:76]});
        end
    end

    // Present one request, after random idle cycles, and hold it until accepted.
    // Called and returns at a falling edge.
    task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [LEN_W-1:0] len,
                                input logic [SKIP_W-1:0] skip,
                                input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, data, skip, len};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_capacity(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        tracker.set_capacity(value);
        capacity_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random request; post_pct steers the ring toward full or toward empty.
    task automatic send_random_request(input int unsigned post_pct);
        logic [TYPE_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic [SKIP_W-1:0] skip;
        int unsigned       roll;
        int unsigned       fill;
        roll = $urandom_range(99);
        if (roll < post_pct)
            kind = $urandom_range(1) ? REQ_POST_ALL : REQ_POST;
        else
            kind = $urandom_range(1) ? REQ_PEEK : REQ_PULL;
        roll = $urandom_range(99);
        if (roll < 4)
            len = '0;
        else if (roll < 10)
            len = LEN_W'($urandom_range(15, 9));
        else
            len = LEN_W'($urandom_range(8, 1));
        // Skips mostly span 0 to fill + 1; a skip of fill or more rejects a peek.
        fill = tracker.level();
        if ($urandom_range(99) < 15)
            skip = SKIP_W'($urandom_range(255));
        else
            skip = SKIP_W'($urandom_range((fill < 255) ? fill + 1 : 255));
        send_request(kind, len, skip, {$urandom(), $urandom()});
    endtask

    // Large rings are first filled, then drained; small ones cycle the bias.
    function automatic int unsigned post_bias(int unsigned idx);
        if (tracker.ring_size >= 200)
            return (idx < 65) ? 95 : 15;
        case ((idx / 25) % 3)
            0:       return 85;
            1:       return 50;
            default: return 15;
        endcase
    endfunction

    task automatic set_idle_mode(input int unsigned mode);
        case (mode % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
        endcase
    endtask

    initial begin
        tracker       = new();
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset size: empty rejects, zero length, saturation.
        set_idle_mode(0);
        send_request(REQ_PULL,     4'd1,  8'd0,   64'h0);
        send_request(REQ_PEEK,     4'd8,  8'd0,   64'h0);
        send_request(REQ_POST,     4'd0,  8'd0,   64'h1122_3344_5566_7788);
        send_request(REQ_POST,     4'd15, 8'd0,   64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_POST_ALL, 4'd8,  8'd0,   64'h0);
        send_request(REQ_PEEK,     4'd8,  8'd0,   64'h0);
        send_request(REQ_PEEK,     4'd8,  8'd15,  64'h0);
        send_request(REQ_PEEK,     4'd8,  8'd16,  64'h0);
        send_request(REQ_PEEK,     4'd8,  8'd255, 64'h0);
        send_request(REQ_PULL,     4'd3,  8'd0,   64'h0);
        send_request(REQ_PULL,     4'd0,  8'd0,   64'h0);
        send_request(REQ_POST_ALL, 4'd0,  8'd0,   64'hFFFF_FFFF_FFFF_FFFF);
        wait_for_results();

        // Directed part on a four-byte ring: full rejects and wraparound.
        write_capacity(32'd4);
        send_request(REQ_POST,     4'd8,  8'd0,   64'hA5A5_5A5A_0F0F_C3D2);
        send_request(REQ_POST,     4'd1,  8'd0,   64'hFF);
        send_request(REQ_POST_ALL, 4'd1,  8'd0,   64'hFF);
        send_request(REQ_PULL,     4'd2,  8'd0,   64'h0);
        send_request(REQ_POST_ALL, 4'd3,  8'd0,   64'h0000_0000_0077_6655);
        send_request(REQ_POST_ALL, 4'd2,  8'd0,   64'h0000_0000_0000_9988);
        send_request(REQ_PEEK,     4'd8,  8'd1,   64'h0);
        send_request(REQ_PULL,     4'd9,  8'd0,   64'h0);
        send_request(REQ_PULL,     4'd1,  8'd0,   64'h0);
        send_request(REQ_PEEK,     4'd1,  8'd0,   64'h0);
        wait_for_results();

        // Random part: one ring size and one idling pattern per phase.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_capacity(phase_cap[ph]);
            set_idle_mode(ph);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Halfway through, let the pipeline run dry before going on.
                if (n == PHASE_ITEMS / 2)
                    wait_for_results();
                send_random_request(post_bias(n));
            end
            wait_for_results();
        end

        $display("Covered %0d requests (%0d post, %0d all-or-nothing, %0d pull, %0d peek);",
                 tracker.kind_count[REQ_POST] + tracker.kind_count[REQ_POST_ALL] +
                 tracker.kind_count[REQ_PULL] + tracker.kind_count[REQ_PEEK],
                 tracker.kind_count[REQ_POST], tracker.kind_count[REQ_POST_ALL],
                 tracker.kind_count[REQ_PULL], tracker.kind_count[REQ_PEEK]);
        $display("%0d rejected, ring full %0d times, %0d pointer wraps, %0d size writes.",
                 tracker.rejects, tracker.full_hits, tracker.wraps, capacity_writes);
        if (tracker.pending() != 0)
            $display("ERROR: %0d results never arrived", tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
